FILE: hdl/dds_serial_register_file_defines.svh
// Assertion macros for the serial register file.
`ifndef DDS_SERIAL_REGISTER_FILE_DEFINES_SVH
`define DDS_SERIAL_REGISTER_FILE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on clk, quiet while arst_n is low.
`define DSRF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dsrf check failed");
// Same check on an explicit clock and reset.
`define DSRF_ASSERT_ON(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error("dsrf check failed");
`else
`define DSRF_ASSERT(label, prop)
`define DSRF_ASSERT_ON(label, clock, rstn, prop)
`endif
`endif

FILE: hdl/dsrf_pkg.sv
// Types, codes and lookup for the serial register file.
package dsrf_pkg;

	typedef enum logic [1:0] {
		ACT_BYTE         = 2'd0,
		ACT_CS_RELEASE   = 2'd1,
		ACT_UPDATE       = 2'd2,
		ACT_MASTER_RESET = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ADDR_SELECT    = 3'd0,
		ADDR_FUNC_ONE  = 3'd1,
		ADDR_FUNC_TWO  = 3'd2,
		ADDR_CHAN_FUNC = 3'd3,
		ADDR_FREQ      = 3'd4,
		ADDR_PHASE     = 3'd5,
		ADDR_AMP       = 3'd6
	} addr_t;

	// Channel enable bits start here in the select register.
	localparam int SEL_EN_LSB = 4;

	typedef struct packed {
		logic [7:0]  active_select;
		logic [23:0] active_function_one;
		logic [15:0] active_function_two;
		logic [23:0] view_channel_function;
		logic [31:0] view_frequency_word;
		logic [15:0] view_phase_word;
		logic [23:0] view_amplitude_word;
		logic        frame_fault;
		logic [2:0]  bytes_pending;
	} result_t;

	// Register length in bytes; unknown addresses have none.
	function automatic logic [2:0] reg_len(input logic [2:0] addr);
		logic [2:0] len;
		unique case (addr)
			ADDR_SELECT:    len = 3'd1;
			ADDR_FUNC_ONE:  len = 3'd3;
			ADDR_FUNC_TWO:  len = 3'd2;
			ADDR_CHAN_FUNC: len = 3'd3;
			ADDR_FREQ:      len = 3'd4;
			ADDR_PHASE:     len = 3'd2;
			ADDR_AMP:       len = 3'd3;
			default:        len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

FILE: hdl/dds_serial_register_file.sv
// Serial register file of a four-channel synthesizer, device side.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid / in_stall    | action, data_byte, view_channel
//  out     | out_valid / out_stall  | active_*, view_*, frame_fault, bytes_pending
//
// One transaction per clock sustained while in_stall is low. The frame decoder
// and all register writes settle in one pass of logic between the input edge
// and the result register. A result register plus a one-entry skid register
// let the block take one more transaction while out_stall holds; in_stall
// rises only once the skid entry is full. Reset (arst_n low) and the master
// reset action zero every register of the file, including the channel select
// register.
`include "dds_serial_register_file_defines.svh"

module dds_serial_register_file #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  view_channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  active_select,
	output logic [23:0] active_function_one,
	output logic [15:0] active_function_two,
	output logic [23:0] view_channel_function,
	output logic [31:0] view_frequency_word,
	output logic [15:0] view_phase_word,
	output logic [23:0] view_amplitude_word,
	output logic        frame_fault,
	output logic [2:0]  bytes_pending
);
	import dsrf_pkg::*;

	// frame decoder state
	logic [2:0]  phase_q, phase_d;
	logic [2:0]  addr_q, addr_d;
	logic        bad_q, bad_d;
	logic [31:0] shift_q, shift_d;

	// global registers
	logic [7:0]  select_q, select_d;
	logic [23:0] fn1_buf_q, fn1_buf_d, fn1_act_q, fn1_act_d;
	logic [15:0] fn2_buf_q, fn2_buf_d, fn2_act_q, fn2_act_d;

	// per-channel registers
	logic [23:0] cfn_buf_q [NUM_CHANNELS];
	logic [23:0] cfn_buf_d [NUM_CHANNELS];
	logic [23:0] cfn_act_q [NUM_CHANNELS];
	logic [23:0] cfn_act_d [NUM_CHANNELS];
	logic [31:0] freq_buf_q [NUM_CHANNELS];
	logic [31:0] freq_buf_d [NUM_CHANNELS];
	logic [31:0] freq_act_q [NUM_CHANNELS];
	logic [31:0] freq_act_d [NUM_CHANNELS];
	logic [15:0] phs_buf_q [NUM_CHANNELS];
	logic [15:0] phs_buf_d [NUM_CHANNELS];
	logic [15:0] phs_act_q [NUM_CHANNELS];
	logic [15:0] phs_act_d [NUM_CHANNELS];
	logic [23:0] amp_buf_q [NUM_CHANNELS];
	logic [23:0] amp_buf_d [NUM_CHANNELS];
	logic [23:0] amp_act_q [NUM_CHANNELS];
	logic [23:0] amp_act_d [NUM_CHANNELS];

	logic [2:0]  got_cnt, cur_len, got_nxt, len_nxt;
	logic [31:0] shift_in;
	logic        fault;
	result_t     res;

	// output side: result register and skid entry
	logic        out_valid_q, skid_valid_q;
	result_t     out_q, skid_q;
	logic        in_take, out_free;

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = skid_valid_q;

	assign got_cnt  = phase_q - 3'd1;
	assign cur_len  = reg_len(addr_q);
	assign shift_in = {shift_q[23:0], data_byte};

	// next state of the whole file for the offered transaction
	always_comb begin
		phase_d   = phase_q;
		addr_d    = addr_q;
		bad_d     = bad_q;
		shift_d   = shift_q;
		select_d  = select_q;
		fn1_buf_d = fn1_buf_q;
		fn1_act_d = fn1_act_q;
		fn2_buf_d = fn2_buf_q;
		fn2_act_d = fn2_act_q;
		cfn_buf_d  = cfn_buf_q;
		cfn_act_d  = cfn_act_q;
		freq_buf_d = freq_buf_q;
		freq_act_d = freq_act_q;
		phs_buf_d  = phs_buf_q;
		phs_act_d  = phs_act_q;
		amp_buf_d  = amp_buf_q;
		amp_act_d  = amp_act_q;
		fault      = 1'b0;

		unique case (action_t'(action))
			ACT_BYTE: begin
				if (phase_q == 3'd0) begin
					// address byte opens the frame
					phase_d = 3'd1;
					shift_d = '0;
					addr_d  = data_byte[2:0];
					bad_d   = (data_byte > 8'(ADDR_AMP));
					fault   = bad_d;
				end else if (bad_q || addr_q > ADDR_AMP || got_cnt >= cur_len) begin
					// bad frame or surplus byte: drop it
					fault = 1'b1;
				end else begin
					shift_d = shift_in;
					phase_d = phase_q + 3'd1;
					if (got_cnt + 3'd1 == cur_len) begin
						// last byte: the write lands
						unique case (addr_q)
							ADDR_SELECT:   select_d  = shift_in[7:0];
							ADDR_FUNC_ONE: fn1_buf_d = shift_in[23:0];
							ADDR_FUNC_TWO: fn2_buf_d = shift_in[15:0];
							default: begin
								for (int c = 0; c < NUM_CHANNELS; c++) begin
									if (select_q[SEL_EN_LSB + c]) begin
										unique case (addr_q)
											ADDR_CHAN_FUNC: cfn_buf_d[c]  = shift_in[23:0];
											ADDR_FREQ:      freq_buf_d[c] = shift_in;
											ADDR_PHASE:     phs_buf_d[c]  = shift_in[15:0];
											default:        amp_buf_d[c]  = shift_in[23:0];
										endcase
									end
								end
							end
						endcase
					end
				end
			end
			ACT_CS_RELEASE: begin
				phase_d = 3'd0;
				bad_d   = 1'b0;
				shift_d = '0;
			end
			ACT_UPDATE: begin
				fn1_act_d  = fn1_buf_q;
				fn2_act_d  = fn2_buf_q;
				cfn_act_d  = cfn_buf_q;
				freq_act_d = freq_buf_q;
				phs_act_d  = phs_buf_q;
				amp_act_d  = amp_buf_q;
			end
			ACT_MASTER_RESET: begin
				phase_d   = '0;
				addr_d    = '0;
				bad_d     = 1'b0;
				shift_d   = '0;
				select_d  = '0;
				fn1_buf_d = '0;
				fn1_act_d = '0;
				fn2_buf_d = '0;
				fn2_act_d = '0;
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					cfn_buf_d[c]  = '0;
					cfn_act_d[c]  = '0;
					freq_buf_d[c] = '0;
					freq_act_d[c] = '0;
					phs_buf_d[c]  = '0;
					phs_act_d[c]  = '0;
					amp_buf_d[c]  = '0;
					amp_act_d[c]  = '0;
				end
			end
		endcase
	end

	assign got_nxt = phase_d - 3'd1;
	assign len_nxt = reg_len(addr_d);

	// result taken after the transaction's effect
	always_comb begin
		res = '0;
		res.active_select       = select_d;
		res.active_function_one = fn1_act_d;
		res.active_function_two = fn2_act_d;
		res.frame_fault         = fault;
		if (phase_d != 3'd0 && !bad_d && addr_d <= ADDR_AMP && got_nxt < len_nxt) begin
			res.bytes_pending = len_nxt - got_nxt;
		end
		// missing channels read as zero
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (view_channel == 2'(c)) begin
				res.view_channel_function = cfn_act_d[c];
				res.view_frequency_word   = freq_act_d[c];
				res.view_phase_word       = phs_act_d[c];
				res.view_amplitude_word   = amp_act_d[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			addr_q    <= '0;
			bad_q     <= 1'b0;
			shift_q   <= '0;
			select_q  <= '0;
			fn1_buf_q <= '0;
			fn1_act_q <= '0;
			fn2_buf_q <= '0;
			fn2_act_q <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				cfn_buf_q[c]  <= '0;
				cfn_act_q[c]  <= '0;
				freq_buf_q[c] <= '0;
				freq_act_q[c] <= '0;
				phs_buf_q[c]  <= '0;
				phs_act_q[c]  <= '0;
				amp_buf_q[c]  <= '0;
				amp_act_q[c]  <= '0;
			end
		end else if (in_take) begin
			phase_q    <= phase_d;
			addr_q     <= addr_d;
			bad_q      <= bad_d;
			shift_q    <= shift_d;
			select_q   <= select_d;
			fn1_buf_q  <= fn1_buf_d;
			fn1_act_q  <= fn1_act_d;
			fn2_buf_q  <= fn2_buf_d;
			fn2_act_q  <= fn2_act_d;
			cfn_buf_q  <= cfn_buf_d;
			cfn_act_q  <= cfn_act_d;
			freq_buf_q <= freq_buf_d;
			freq_act_q <= freq_act_d;
			phs_buf_q  <= phs_buf_d;
			phs_act_q  <= phs_act_d;
			amp_buf_q  <= amp_buf_d;
			amp_act_q  <= amp_act_d;
		end
	end

	// output valids: skid drains first, new results go where there is room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_take;
			skid_valid_q <= 1'b0;
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_take) begin
				out_q <= res;
			end
		end else if (in_take) begin
			skid_q <= res;
		end
	end

	assign out_valid             = out_valid_q;
	assign active_select         = out_q.active_select;
	assign active_function_one   = out_q.active_function_one;
	assign active_function_two   = out_q.active_function_two;
	assign view_channel_function = out_q.view_channel_function;
	assign view_frequency_word   = out_q.view_frequency_word;
	assign view_phase_word       = out_q.view_phase_word;
	assign view_amplitude_word   = out_q.view_amplitude_word;
	assign frame_fault           = out_q.frame_fault;
	assign bytes_pending         = out_q.bytes_pending;

	// skid entry is only ever behind a held result
	`DSRF_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q)
	// after an accepted transaction a result is held valid next cycle
	`DSRF_ASSERT(a_take_gives_result, in_take |=> out_valid_q)
	// a bad frame never gets past its address byte
	`DSRF_ASSERT_ON(a_bad_frame_parked, clk, arst_n, bad_q |-> phase_q == 3'd1)
	// pending count stays within the longest register
	`DSRF_ASSERT(a_pending_range, out_valid_q |-> out_q.bytes_pending <= 3'd4)

endmodule
